// ===== src/idm_pkg.sv =====
// ----------------------------------------------------------------------------
// idm_pkg
// Shared widths, limits, controller commands and status for the
// interpolated delay mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package idm_pkg;

  localparam int unsigned DelayDepthDef = 4096;

  localparam int unsigned SampleW = 24;
  localparam int unsigned OffsetW = 13;
  localparam int unsigned MixW    = 15;

  localparam logic signed [OffsetW-1:0] OffsetMax = 13'sd2560;
  localparam logic signed [OffsetW-1:0] OffsetMin = -13'sd2560;

  // Controller to datapath commands, one per step of an item
  typedef struct packed {
    logic load;      // capture the input transaction
    logic addr;      // form read addresses and the dry product
    logic read;      // read both taps, store the new sample
    logic wet;       // interpolate between the taps
    logic mix;       // weight and sum
    logic out_load;  // round, saturate, load the output register
  } idm_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being taken
  } idm_status_t;

endpackage

`default_nettype wire

// ===== src/idm_if.sv =====
// ----------------------------------------------------------------------------
// idm_if
// Valid/ready stream interfaces for the input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface idm_in_if
  import idm_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      channel;
  logic signed [SampleW-1:0] sample_in;
  logic signed [OffsetW-1:0] delay_offset;
  logic [MixW-1:0]           mix_amount;

  modport source (output valid, channel, sample_in, delay_offset, mix_amount, input ready);
  modport sink (input valid, channel, sample_in, delay_offset, mix_amount, output ready);
endinterface

interface idm_out_if
  import idm_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      channel_out;
  logic signed [SampleW-1:0] sample_out;

  modport source (output valid, channel_out, sample_out, input ready);
  modport sink (input valid, channel_out, sample_out, output ready);
endinterface

`default_nettype wire

// ===== src/interpolated_delay_mixer.sv =====
// ----------------------------------------------------------------------------
// interpolated_delay_mixer
// Two-channel fractional delay with linear interpolation and wet/dry mix.
// ----------------------------------------------------------------------------
// Each transaction takes one item through these steps: capture, address
// forming with the dry product, an access at the ring store port (both taps
// read, new sample stored), interpolation, weighting, and the load of the
// output register. The next item is taken only after the previous one has
// been loaded there; that load waits while a finished result still sits in
// the output register. Each channel has a ring of DELAY_DEPTH samples; taps
// never written since reset read as zero, so no clearing pass follows reset.
`default_nettype none

module interpolated_delay_mixer
  import idm_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH = DelayDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  idm_in_if.sink    in_i,
  idm_out_if.source out_o
);

  idm_cmd_t    cmd;
  idm_status_t sts;
  logic        in_ready;

  assign in_i.ready = in_ready;

  idm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  idm_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .channel_i      (in_i.channel),
    .sample_in_i    (in_i.sample_in),
    .delay_offset_i (in_i.delay_offset),
    .mix_amount_i   (in_i.mix_amount),
    .out_ready_i    (out_o.ready),
    .sts_o          (sts),
    .out_valid_o    (out_o.valid),
    .channel_out_o  (out_o.channel_out),
    .sample_out_o   (out_o.sample_out)
  );

endmodule

`default_nettype wire

// ===== src/idm_ctrl.sv =====
// ----------------------------------------------------------------------------
// idm_ctrl
// Sequencer for one item: accept, address, read/store, interpolate, mix,
// output.
// ----------------------------------------------------------------------------
`default_nettype none

module idm_ctrl
  import idm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire idm_status_t sts_i,
  output idm_cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADDR = 6'b000010,
    S_READ = 6'b000100,
    S_WET  = 6'b001000,
    S_MIX  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_WET;
      end
      S_WET: begin
        cmd_o.wet = 1'b1;
        state_d   = S_MIX;
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/idm_datapath.sv =====
// ----------------------------------------------------------------------------
// idm_datapath
// Ring stores, write pointers, interpolation and wet/dry mix arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module idm_datapath
  import idm_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH = DelayDepthDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire idm_cmd_t                  cmd_i,
  input  wire logic                      channel_i,
  input  wire logic signed [SampleW-1:0] sample_in_i,
  input  wire logic signed [OffsetW-1:0] delay_offset_i,
  input  wire logic [MixW-1:0]           mix_amount_i,
  input  wire logic                      out_ready_i,
  output idm_status_t                    sts_o,
  output logic                           out_valid_o,
  output logic                           channel_out_o,
  output logic signed [SampleW-1:0]      sample_out_o
);

  localparam int unsigned AW   = $clog2(DELAY_DEPTH);
  localparam int unsigned PW   = AW + 10;
  localparam int unsigned PXW  = SampleW + 18;
  localparam int unsigned WETW = 32;
  localparam int unsigned ACCW = 50;
  localparam int unsigned YW   = ACCW - 24;

  localparam logic signed [PW-1:0]   Span    = PW'(DELAY_DEPTH * 256);
  localparam logic [AW-1:0]          LastIdx = AW'(DELAY_DEPTH - 1);
  localparam logic signed [ACCW-1:0] RndHalf = ACCW'(64'sd8388608);
  localparam logic signed [YW-1:0]   YMax    = YW'(32'sd8388607);
  localparam logic signed [YW-1:0]   YMin    = YW'(-32'sd8388608);

  // captured transaction
  logic                      ch_q;
  logic signed [SampleW-1:0] x_q;
  logic signed [OffsetW-1:0] off_q, off_d;
  logic [MixW-1:0]           mix_q;

  // per channel write pointer and wrap flag
  logic [AW-1:0] wptr_q [2];
  logic          wrap_q [2];

  logic [AW-1:0]          ia_q, ib_q, ia_d, ib_d, w_cur;
  logic [7:0]             f_q;
  logic                   va_q, vb_q;
  logic signed [PW-1:0]   pos_raw, pos_wrap;
  logic [16:0]            inv_mix;
  logic signed [PXW-1:0]  px_q, px_d;

  logic [SampleW-1:0] mem_l_q [DELAY_DEPTH];
  logic [SampleW-1:0] mem_r_q [DELAY_DEPTH];
  logic [SampleW-1:0] a_l_q, b_l_q, a_r_q, b_r_q;

  logic signed [SampleW-1:0] tap_a, tap_b;
  logic [8:0]                fa;
  logic signed [WETW-1:0]    wet_q, wet_d;
  logic signed [ACCW-1:0]    acc_q, acc_d, rnd;
  logic signed [YW-1:0]      y;
  logic signed [SampleW-1:0] y_sat;

  logic                      out_valid_q;
  logic                      out_ch_q;
  logic signed [SampleW-1:0] out_sample_q;

  // clamp offset to plus or minus ten samples
  always_comb begin
    if (delay_offset_i > OffsetMax) begin
      off_d = OffsetMax;
    end else if (delay_offset_i < OffsetMin) begin
      off_d = OffsetMin;
    end else begin
      off_d = delay_offset_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q  <= channel_i;
      x_q   <= sample_in_i;
      off_q <= off_d;
      mix_q <= mix_amount_i;
    end
  end

  // read position, wrapped once either way
  assign w_cur    = wptr_q[ch_q];
  assign pos_raw  = $signed({2'b00, w_cur, 8'h00}) - PW'(off_q);
  always_comb begin
    if (pos_raw < 0) begin
      pos_wrap = pos_raw + Span;
    end else if (pos_raw >= Span) begin
      pos_wrap = pos_raw - Span;
    end else begin
      pos_wrap = pos_raw;
    end
  end
  assign ia_d    = pos_wrap[AW+7:8];
  assign ib_d    = (ia_d == LastIdx) ? '0 : ia_d + 1'b1;
  assign inv_mix = 17'h10000 - {2'b00, mix_q};
  assign px_d    = x_q * $signed({1'b0, inv_mix});

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr) begin
      ia_q <= ia_d;
      ib_q <= ib_d;
      f_q  <= pos_wrap[7:0];
      // entries never written since reset read as zero
      va_q <= wrap_q[ch_q] || (ia_d < w_cur);
      vb_q <= wrap_q[ch_q] || (ib_d < w_cur);
      px_q <= px_d;
    end
  end

  // ring stores: read both taps before storing the new sample
  always_ff @(posedge clk_i) begin
    if (cmd_i.read && !ch_q) begin
      mem_l_q[w_cur] <= x_q;
    end
    if (cmd_i.read) begin
      a_l_q <= mem_l_q[ia_q];
      b_l_q <= mem_l_q[ib_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read && ch_q) begin
      mem_r_q[w_cur] <= x_q;
    end
    if (cmd_i.read) begin
      a_r_q <= mem_r_q[ia_q];
      b_r_q <= mem_r_q[ib_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q[0] <= '0;
      wptr_q[1] <= '0;
      wrap_q[0] <= 1'b0;
      wrap_q[1] <= 1'b0;
    end else if (cmd_i.read) begin
      if (w_cur == LastIdx) begin
        wptr_q[ch_q] <= '0;
        wrap_q[ch_q] <= 1'b1;
      end else begin
        wptr_q[ch_q] <= w_cur + 1'b1;
      end
    end
  end

  // linear interpolation, eight fractional bits
  assign tap_a = !va_q ? '0 : (ch_q ? $signed(a_r_q) : $signed(a_l_q));
  assign tap_b = !vb_q ? '0 : (ch_q ? $signed(b_r_q) : $signed(b_l_q));
  assign fa    = 9'd256 - {1'b0, f_q};
  assign wet_d = tap_a * $signed({1'b0, fa}) + tap_b * $signed({2'b00, f_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.wet) begin
      wet_q <= wet_d;
    end
  end

  assign acc_d = $signed({px_q, 8'h00}) + wet_q * $signed({1'b0, mix_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix) begin
      acc_q <= acc_d;
    end
  end

  // round half up, then saturate
  assign rnd = acc_q + RndHalf;
  assign y   = rnd[ACCW-1:24];
  always_comb begin
    if (y > YMax) begin
      y_sat = YMax[SampleW-1:0];
    end else if (y < YMin) begin
      y_sat = YMin[SampleW-1:0];
    end else begin
      y_sat = y[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ch_q     <= ch_q;
      out_sample_q <= y_sat;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign channel_out_o  = out_ch_q;
  assign sample_out_o   = out_sample_q;

  a_wptr_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.read |=> wptr_q[ch_q] == (($past(w_cur) == LastIdx) ? AW'(0)
                                    : AW'($past(w_cur) + 1'b1)))
    else $error("write pointer did not advance after the store");

  a_taps_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.addr |=> (ia_q <= LastIdx) && (ib_q <= LastIdx))
    else $error("tap address beyond the ring");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q && (out_ch_q == $past(ch_q)))
    else $error("result not presented after output load");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the interpolated delay mixer. A directed table opens
// the run, then random transactions under three idling patterns. Each result
// is checked against a typed sample, else a local model of rings and pointers.
// ----------------------------------------------------------------------------
module tb_top
  import idm_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH = DelayDepthDef;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam longint      RING_SPAN  = longint'(RING_DEPTH) * 256;
  localparam longint      SMP_HI     = 8388607;
  localparam longint      SMP_LO     = -8388608;
  localparam int          CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic                      ch;
    logic signed [SampleW-1:0] smp;
    logic signed [OffsetW-1:0] off;
    logic [MixW-1:0]           mix;
    logic                      known;  // expected sample typed in below
    logic signed [SampleW-1:0] want;
  } stim_row_t;

  typedef struct packed {
    logic                      ch;
    logic signed [SampleW-1:0] smp;
  } mix_result_t;

  localparam int NUM_DIRECTED = 19;

  // Both rings are zero after reset, so the first rows with no wet weight
  // pass the dry sample straight through.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b0, 24'h7fffff, 13'h0000, 15'h0000, 1'b1, 24'h7fffff},
    '{1'b0, 24'h800000, 13'h0000, 15'h0000, 1'b1, 24'h800000},
    '{1'b1, 24'h000000, 13'h0000, 15'h7fff, 1'b1, 24'h000000},
    '{1'b1, 24'h000001, 13'h0a00, 15'h0000, 1'b1, 24'h000001},
    '{1'b0, 24'd1000,   13'h0100, 15'h7fff, 1'b0, 24'h0},
    '{1'b0, -24'sd1000, 13'h0200, 15'h7fff, 1'b0, 24'h0},
    '{1'b0, 24'd500,    13'h0180, 15'd19661, 1'b0, 24'h0},
    '{1'b0, 24'h3fffff, 13'h0001, 15'h4000, 1'b0, 24'h0},
    '{1'b0, 24'hc00000, 13'h1fff, 15'h2000, 1'b0, 24'h0},
    '{1'b0, 24'h012345, 13'h0fff, 15'd19661, 1'b0, 24'h0},
    '{1'b0, 24'hfedcba, 13'h1000, 15'd19661, 1'b0, 24'h0},
    '{1'b1, 24'h7fffff, 13'h1600, 15'h7fff, 1'b0, 24'h0},
    '{1'b1, 24'h800000, 13'h0a00, 15'h7fff, 1'b0, 24'h0},
    '{1'b1, 24'h123456, 13'h012c, 15'h0000, 1'b1, 24'h123456},
    '{1'b0, 24'h7fffff, 13'h0100, 15'h7fff, 1'b0, 24'h0},
    '{1'b0, 24'h800000, 13'h00ff, 15'h7fff, 1'b0, 24'h0},
    '{1'b1, 24'h555555, 13'h0aaa, 15'h2aaa, 1'b0, 24'h0},
    '{1'b1, 24'haaaaaa, 13'h1555, 15'h5555, 1'b0, 24'h0},
    '{1'b1, 24'h000000, 13'h0000, 15'h0000, 1'b1, 24'h000000}
  };

  logic clk_i;
  logic rst_ni;

  idm_in_if  in_bus ();
  idm_out_if out_bus ();

  interpolated_delay_mixer #(
    .DELAY_DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  logic signed [SampleW-1:0] ring_model [2][RING_DEPTH];
  logic [PTR_W-1:0]          wr_ptr_model [2];
  mix_result_t               pending_out [$];
  int                        error_count;
  int                        cycle_count;
  int                        src_gap_pct;
  int                        rx_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Read both taps, store the new sample, advance the pointer, then weight.
  function automatic logic signed [SampleW-1:0] delayed_mix(input stim_row_t row);
    longint off, pos, f, a, b, wet, xs, ms, acc, y;
    int unsigned w, ia, ib;
    off = row.off;
    if (off > OffsetMax) off = OffsetMax;
    if (off < OffsetMin) off = OffsetMin;
    w   = wr_ptr_model[row.ch];
    pos = longint'(w) * 256 - off;
    if (pos < 0) pos += RING_SPAN;
    if (pos >= RING_SPAN) pos -= RING_SPAN;
    ia  = int'(pos >> 8);
    f   = pos & 255;
    ib  = (ia + 1) % RING_DEPTH;
    a   = ring_model[row.ch][ia];
    b   = ring_model[row.ch][ib];
    wet = a * (256 - f) + b * f;
    ring_model[row.ch][w] = row.smp;
    wr_ptr_model[row.ch]  = PTR_W'((w + 1) % RING_DEPTH);
    xs  = row.smp;
    ms  = row.mix;
    acc = xs * (65536 - ms) * 256 + wet * ms;
    y   = (acc + 64'sd8388608) >>> 24;
    if (y > SMP_HI) y = SMP_HI;
    if (y < SMP_LO) y = SMP_LO;
    return y[SampleW-1:0];
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int        sel;
    r       = '0;
    r.ch    = 1'($urandom_range(1));
    sel     = $urandom_range(9);
    if (sel == 0) r.smp = 24'h7fffff;
    else if (sel == 1) r.smp = 24'h800000;
    else r.smp = SampleW'($urandom);
    sel = $urandom_range(19);
    if (sel < 3) r.off = '0;
    else if (sel == 3) r.off = OffsetW'($urandom);
    else if (sel == 4) r.off = $urandom_range(1) ? OffsetMax : OffsetMin;
    else r.off = OffsetW'(int'($urandom_range(5120)) - 2560);
    sel = $urandom_range(9);
    if (sel == 0) r.mix = '0;
    else if (sel == 1) r.mix = MixW'($urandom);
    else if (sel == 2) r.mix = MixW'(19661);
    else r.mix = MixW'($urandom_range(19661));
    return r;
  endfunction

  task automatic send_sample(input stim_row_t row);
    mix_result_t exp;
    while ($urandom_range(99) < src_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.channel      <= row.ch;
    in_bus.sample_in    <= row.smp;
    in_bus.delay_offset <= row.off;
    in_bus.mix_amount   <= row.mix;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    exp.ch  = row.ch;
    exp.smp = delayed_mix(row);
    if (row.known) exp.smp = row.want;
    pending_out.push_back(exp);
    @(negedge clk_i);
  endtask

  // Hold the input idle until every outstanding result has come back.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    mix_result_t exp;
    if (out_bus.valid && out_bus.ready) begin
      if (pending_out.size() == 0) begin
        $error("result with no transaction outstanding: channel %0d sample %0d",
               out_bus.channel_out, out_bus.sample_out);
        error_count++;
      end else begin
        exp = pending_out.pop_front();
        if (out_bus.channel_out !== exp.ch) begin
          $error("channel_out: expected %0d, got %0d", exp.ch, out_bus.channel_out);
          error_count++;
        end
        if (out_bus.sample_out !== exp.smp) begin
          $error("sample_out: expected %0d, got %0d", exp.smp, out_bus.sample_out);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count  = 0;
    cycle_count  = 0;
    src_gap_pct  = 0;
    rx_stall_pct = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_model[0][i] = '0;
      ring_model[1][i] = '0;
    end
    wr_ptr_model[0]     = '0;
    wr_ptr_model[1]     = '0;
    in_bus.valid        = 1'b0;
    in_bus.channel      = 1'b0;
    in_bus.sample_in    = '0;
    in_bus.delay_offset = '0;
    in_bus.mix_amount   = '0;
    rst_ni              = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) send_sample(directed_rows[i]);
    drain_results();

    src_gap_pct  = 8;
    rx_stall_pct = 49;
    for (int i = 0; i < 530; i++) send_sample(random_row());
    drain_results();

    src_gap_pct  = 49;
    rx_stall_pct = 8;
    for (int i = 0; i < 530; i++) send_sample(random_row());
    drain_results();

    src_gap_pct  = 0;
    rx_stall_pct = 0;
    for (int i = 0; i < 520; i++) send_sample(random_row());
    drain_results();

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== interpolated_delay_mixer.f =====
src/idm_pkg.sv
src/idm_if.sv
src/idm_ctrl.sv
src/idm_datapath.sv
src/interpolated_delay_mixer.sv
tb/sv/tb_top.sv
